### sv/kws_pkg.sv
package kws_pkg;

   localparam int KwCount     = 39;
   localparam int KwTextBytes = 14;

   localparam logic [7:0] ColonByte      = 8'h3A;
   localparam logic [7:0] UnderscoreByte = 8'h5F;

   localparam logic [5:0] CodeIdent = 6'd0;
   localparam logic [5:0] CodeLabel = 6'd1;

   typedef struct packed {
      logic [7:0]  source_byte;
      logic [15:0] line_number;
      logic [15:0] column_number;
   } req_type;

   typedef struct packed {
      logic        token_valid;
      logic [5:0]  token_code;
      logic [7:0]  token_length;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic        byte_consumed;
      logic        length_overflow;
   } rsp_type;

   // Keyword spellings, right aligned: the last character sits in the low byte.
   localparam logic [8*KwTextBytes-1:0] KW_TEXT [KwCount] = '{
      "if", "else", "do", "while", "for", "break", "continue", "goto",
      "switch", "case", "default", "sizeof", "int", "char", "float",
      "double", "short", "long", "bool", "_Bool", "_Complex", "alignas",
      "_Alignof", "unsigned", "void", "enum", "struct", "union", "typedef",
      "static", "extern", "const", "volatile", "restrict", "register",
      "inline", "_Noreturn", {"_Static", "_assert"}, "return"
   };

   localparam logic [3:0] KW_SIZE [KwCount] = '{
      4'd2, 4'd4, 4'd2, 4'd5, 4'd3, 4'd5, 4'd8, 4'd4, 4'd6, 4'd4,
      4'd7, 4'd6, 4'd3, 4'd4, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd5,
      4'd8, 4'd7, 4'd8, 4'd8, 4'd4, 4'd4, 4'd6, 4'd5, 4'd7, 4'd6,
      4'd6, 4'd5, 4'd8, 4'd8, 4'd8, 4'd6, 4'd9, 4'd14, 4'd6
   };

   // The bool and _Bool spellings share one token code.
   localparam logic [5:0] KW_CODE [KwCount] = '{
      6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11,
      6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd20,
      6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
      6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39
   };

   function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] pos);
      int idx;
      idx = int'(KW_SIZE[k]) - 1 - int'(pos);
      if (idx < 0) begin
         return 8'h00;
      end
      return KW_TEXT[k][idx*8 +: 8];
   endfunction

endpackage

### sv/kws_stream_if.sv
interface kws_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/kws_kwmatch.sv
module kws_kwmatch #(
   parameter int LenWidth = 8
) (
   input  logic [kws_pkg::KwCount-1:0] mask,
   input  logic [LenWidth-1:0]         pos,
   input  logic [7:0]                  src_char,
   output logic [kws_pkg::KwCount-1:0] next_mask,
   input  logic [kws_pkg::KwCount-1:0] final_mask,
   input  logic [LenWidth-1:0]         final_len,
   input  logic                        final_overflow,
   output logic [5:0]                  final_code
);
   import kws_pkg::*;

   // Each keyword keeps its bit only if the character at this position matches.
   always_comb begin
      for (int k = 0; k < KwCount; k++) begin
         next_mask[k] = mask[k] && (pos < LenWidth'(KW_SIZE[k]))
                        && (kw_char(k, pos[3:0]) == src_char);
      end
   end

   // Lowest table entry whose length equals the identifier length wins.
   always_comb begin
      final_code = CodeIdent;
      for (int k = KwCount - 1; k >= 0; k--) begin
         if (final_mask[k] && (final_len == LenWidth'(KW_SIZE[k]))) begin
            final_code = KW_CODE[k];
         end
      end
      if (final_overflow) begin
         final_code = CodeIdent;
      end
   end

endmodule

### sv/kws_scan.sv
module kws_scan #(
   parameter int MAX_IDENT_LEN = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  kws_pkg::req_type item,
   output kws_pkg::rsp_type result
);
   import kws_pkg::*;

   localparam int LenWidth = $clog2(MAX_IDENT_LEN + 1);
   localparam logic [LenWidth-1:0] LenMax = LenWidth'(MAX_IDENT_LEN);

   logic                inside_ff, inside_in;
   logic [LenWidth-1:0] len_ff, len_in;
   logic                ovf_ff, ovf_in;
   logic [15:0]         line_ff, line_in;
   logic [15:0]         col_ff, col_in;
   logic [KwCount-1:0]  cand_ff, cand_in;

   logic                is_letter, is_digit, is_under, ident_char;
   logic [KwCount-1:0]  sel_mask, narrowed;
   logic [LenWidth-1:0] sel_pos;
   logic [5:0]          code;
   logic [LenWidth+7:0] len_ext;

   assign is_letter  = (item.source_byte >= 8'h41 && item.source_byte <= 8'h5A)
                    || (item.source_byte >= 8'h61 && item.source_byte <= 8'h7A);
   assign is_digit   = item.source_byte >= 8'h30 && item.source_byte <= 8'h39;
   assign is_under   = item.source_byte == UnderscoreByte;
   assign ident_char = is_letter || is_digit || is_under;

   assign sel_mask = inside_ff ? cand_ff : {KwCount{1'b1}};
   assign sel_pos  = inside_ff ? len_ff : '0;
   assign len_ext  = {8'b0, len_ff};

   kws_kwmatch #(.LenWidth(LenWidth)) u_kwmatch (
      .mask           (sel_mask),
      .pos            (sel_pos),
      .src_char       (item.source_byte),
      .next_mask      (narrowed),
      .final_mask     (cand_ff),
      .final_len      (len_ff),
      .final_overflow (ovf_ff),
      .final_code     (code)
   );

   always_comb begin
      inside_in = inside_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      cand_in   = cand_ff;
      result    = '0;
      if (!inside_ff) begin
         if (is_letter || is_under) begin
            inside_in            = 1'b1;
            len_in               = LenWidth'(1);
            ovf_in               = 1'b0;
            line_in              = item.line_number;
            col_in               = item.column_number;
            cand_in              = narrowed;
            result.byte_consumed = 1'b1;
         end
      end else if (ident_char) begin
         cand_in = narrowed;
         if (len_ff >= LenMax) begin
            len_in = LenMax;
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + LenWidth'(1);
         end
         result.byte_consumed = 1'b1;
      end else begin
         result.token_valid     = 1'b1;
         result.token_length    = len_ext[7:0];
         result.token_line      = line_ff;
         result.token_column    = col_ff;
         result.length_overflow = ovf_ff;
         if (item.source_byte == ColonByte) begin
            result.token_code    = CodeLabel;
            result.byte_consumed = 1'b1;
         end else begin
            result.token_code    = code;
         end
         inside_in = 1'b0;
         len_in    = '0;
         ovf_in    = 1'b0;
         cand_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         cand_ff   <= '0;
      end else if (advance) begin
         inside_ff <= inside_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         cand_ff   <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

endmodule

### sv/identifier_keyword_scanner.sv
// An accepted source byte waits in the input register; its result is then registered
// in the result register. Throughput: one byte per cycle while rsp is not stalled;
// the keyword mask and length update in one pass.
// A stalled result register holds the pipeline; the input register keeps one byte.
// Reset (synchronous, active high) empties both registers and leaves no open identifier.
module identifier_keyword_scanner #(
   parameter int MAX_IDENT_LEN = 255
) (
   input logic       clock,
   input logic       reset,
   kws_stream_if.sink   req,
   kws_stream_if.source rsp
);
   import kws_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type result;
   logic    advance;

   // The held byte moves on when the result register is empty or being drained.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_item_ff;

   always_comb begin
      in_valid_in  = req.ready ? req.valid : in_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   kws_scan #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff <= req.payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

endmodule

### verif/identifier_keyword_scanner_test.sv
`timescale 1ns / 100ps

module identifier_keyword_scanner_test;

   import kws_pkg::*;

   localparam int MaxWordLen = 255;
   localparam int RandomBytes = 850;
   localparam int CycleLimit = 1_000_000;
   localparam logic [7:0] SpaceByte = 8'h20;
   localparam logic [7:0] NulByte = 8'h00;

   logic clock;
   logic reset;

   kws_stream_if #(.payload_type(req_type)) req_if ();
   kws_stream_if #(.payload_type(rsp_type)) rsp_if ();

   identifier_keyword_scanner #(
      .MAX_IDENT_LEN(MaxWordLen)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if)
   );

   string kw_spelling [39] = '{
      "if", "else", "do", "while", "for", "break", "continue", "goto",
      "switch", "case", "default", "sizeof", "int", "char", "float",
      "double", "short", "long", "bool", "_Bool", "_Complex", "alignas",
      "_Alignof", "unsigned", "void", "enum", "struct", "union", "typedef",
      "static", "extern", "const", "volatile", "restrict", "register",
      "inline", "_Noreturn", {"_Static", "_assert"}, "return"
   };

   // Copy of the scanner's identifier state.
   bit              in_word;
   int unsigned     word_len;
   bit              word_overflow;
   logic [15:0]     word_line;
   logic [15:0]     word_column;
   string           word_text;

   rsp_type         expected_tokens [$];
   int unsigned     error_count;
   int unsigned     cycle_count;
   bit              steady_flow;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Some tests failed");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_flow) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 50);
   endfunction

   function automatic bit is_letter(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic bit is_word_byte(logic [7:0] b);
      return is_letter(b) || (b >= "0" && b <= "9") || b == UnderscoreByte;
   endfunction

   function automatic logic [5:0] keyword_code(string s);
      for (int k = 0; k < 39; k++) begin
         if (s == kw_spelling[k]) begin
            // bool and _Bool share one code, so later entries shift down by one.
            return (k <= 18) ? 6'(k + 2) : 6'(k + 1);
         end
      end
      return CodeIdent;
   endfunction

   function automatic rsp_type scan_byte(req_type item);
      rsp_type     token;
      logic [7:0]  b;
      token = '0;
      b = item.source_byte;
      if (!in_word) begin
         if (is_letter(b) || b == UnderscoreByte) begin
            in_word = 1'b1;
            word_len = 1;
            word_overflow = 1'b0;
            word_line = item.line_number;
            word_column = item.column_number;
            word_text = $sformatf("%c", b);
            token.byte_consumed = 1'b1;
         end
         return token;
      end
      if (is_word_byte(b)) begin
         if (word_len >= MaxWordLen) begin
            word_overflow = 1'b1;
         end else begin
            word_len++;
         end
         // Keywords are at most 14 bytes, so a longer tail never matters.
         if (word_text.len() < 16) begin
            word_text = {word_text, $sformatf("%c", b)};
         end
         token.byte_consumed = 1'b1;
         return token;
      end
      token.token_valid = 1'b1;
      token.token_length = word_len[7:0];
      token.token_line = word_line;
      token.token_column = word_column;
      token.length_overflow = word_overflow;
      if (b == ColonByte) begin
         token.token_code = CodeLabel;
         token.byte_consumed = 1'b1;
      end else begin
         token.token_code = word_overflow ? CodeIdent : keyword_code(word_text);
         token.byte_consumed = 1'b0;
      end
      in_word = 1'b0;
      word_len = 0;
      word_overflow = 1'b0;
      word_line = '0;
      word_column = '0;
      word_text = "";
      return token;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= 100) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   task automatic compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("field %s: got %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic check_token(rsp_type got);
      rsp_type want;
      want = expected_tokens.pop_front();
      compare_field("token_valid", got.token_valid, want.token_valid);
      compare_field("token_code", got.token_code, want.token_code);
      compare_field("token_length", got.token_length, want.token_length);
      compare_field("token_line", got.token_line, want.token_line);
      compare_field("token_column", got.token_column, want.token_column);
      compare_field("byte_consumed", got.byte_consumed, want.byte_consumed);
      compare_field("length_overflow", got.length_overflow, want.length_overflow);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("result transaction with no expected result pending");
         end else begin
            check_token(rsp_if.payload);
         end
      end
   end

   // Result side: ready runs of random length broken by stalls.
   initial begin
      int unsigned stall;
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         stall = pick_gap();
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      req_type     item;
      int unsigned gap;
      item.source_byte = b;
      item.line_number = 16'($urandom_range(0, 65535));
      item.column_number = 16'($urandom_range(0, 65535));
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_tokens.push_back(scan_byte(item));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   function automatic logic [7:0] random_word_byte();
      int unsigned idx;
      idx = $urandom_range(0, 62);
      if (idx < 26) begin
         return 8'("a" + idx);
      end
      if (idx < 52) begin
         return 8'("A" + idx - 26);
      end
      if (idx < 62) begin
         return 8'("0" + idx - 52);
      end
      return UnderscoreByte;
   endfunction

   function automatic string random_word(int unsigned n);
      string       s;
      logic [7:0]  c;
      do begin
         c = random_word_byte();
      end while (!(is_letter(c) || c == UnderscoreByte));
      s = $sformatf("%c", c);
      for (int i = 1; i < n; i++) begin
         s = {s, $sformatf("%c", random_word_byte())};
      end
      return s;
   endfunction

   function automatic logic [7:0] random_terminator();
      int unsigned r;
      logic [7:0]  b;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         return ColonByte;
      end
      if (r < 45) begin
         return SpaceByte;
      end
      if (r < 55) begin
         return NulByte;
      end
      if (r < 70) begin
         return 8'($urandom_range(128, 255));
      end
      do begin
         b = 8'($urandom_range(0, 255));
      end while (is_word_byte(b));
      return b;
   endfunction

   task automatic test_directed();
      send_text("if ");
      send_text("_Bool");
      send_byte(NulByte);
      send_text("default:");
      // Bytes that cannot open an identifier, then a one-letter identifier Z.
      send_byte("9");
      send_byte(ColonByte);
      send_byte(8'hFF);
      send_byte(NulByte);
      send_byte("Z");
      send_byte(8'h80);
      send_text("_7 ");
   endtask

   task automatic test_length_limit();
      send_text(random_word(MaxWordLen));
      send_byte(SpaceByte);
      send_text(random_word(MaxWordLen + 1));
      send_byte(ColonByte);
      send_text({"int", random_word(MaxWordLen + 40)});
      send_byte(SpaceByte);
      send_text({"_Static", "_assert", "x"});
      send_byte(SpaceByte);
   endtask

   task automatic test_random_text();
      int unsigned word_bytes;
      int unsigned r;
      string       s;
      word_bytes = 0;
      while (word_bytes < RandomBytes) begin
         if ($urandom_range(0, 39) == 0) begin
            steady_flow = !steady_flow;
         end
         r = $urandom_range(0, 99);
         if (r >= 85) begin
            // Noise the scanner mostly ignores.
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0) begin
                  send_byte(8'("0" + $urandom_range(0, 9)));
               end else begin
                  send_byte(8'($urandom_range(0, 255)));
               end
            end
            if (in_word) begin
               send_byte(random_terminator());
            end
            continue;
         end
         if (r < 45) begin
            s = kw_spelling[$urandom_range(0, 38)];
         end else if (r < 60) begin
            s = kw_spelling[$urandom_range(0, 38)];
            case ($urandom_range(0, 2))
               0: begin
                  s = (s.len() > 1) ? s.substr(0, s.len() - 2) : {s, "_"};
               end
               1: begin
                  s = {s, $sformatf("%c", random_word_byte())};
               end
               default: begin
                  s = s.toupper();
               end
            endcase
         end else if ($urandom_range(0, 9) == 0) begin
            s = random_word($urandom_range(20, 40));
         end else begin
            s = random_word($urandom_range(1, 12));
         end
         send_text(s);
         send_byte(random_terminator());
         word_bytes += s.len() + 1;
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      error_count = 0;
      cycle_count = 0;
      steady_flow = 1'b0;
      in_word = 1'b0;
      word_len = 0;
      word_overflow = 1'b0;
      word_line = '0;
      word_column = '0;
      word_text = "";
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_length_limit();
      test_random_text();

      req_if.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
